// ----- design/sac_pkg.sv -----
// Shared codes for the set-associative write-back cache.
package sac_pkg;

	// request modes
	localparam logic [1:0] MODE_WRITE  = 2'd0;
	localparam logic [1:0] MODE_READ   = 2'd1;
	localparam logic [1:0] MODE_FLUSH  = 2'd2;
	localparam logic [1:0] MODE_UNUSED = 2'd3;

	// event counter slots
	localparam int CNT_RD_HIT  = 0;
	localparam int CNT_RD_MISS = 1;
	localparam int CNT_WR_HIT  = 2;
	localparam int CNT_WR_MISS = 3;
	localparam int CNT_WB      = 4;
	localparam int CNT_NUM     = 5;

endpackage

// ----- design/set_assoc_writeback_lru_cache.sv -----
// Top level: set-associative write-back LRU cache with its backing store.
// Hit: a write passes S_LOOK, S_ACC and S_RESP before its result is registered; a read adds S_DATA.
// Miss: a line fill (S_FILL) comes before S_ACC, preceded by a write-back (S_WB) for a dirty victim.
// Flush: each set is read in S_FRD, each line checked in S_FCHK and cleared in S_FNXT, dirty lines written back.
// One request at a time; the next is taken while a finished result waits on out_stall.
// After reset a clearing pass loads the backing store (in_stall high).
module set_assoc_writeback_lru_cache
	import sac_pkg::*;
#(
	parameter int SETS        = 16,
	parameter int WAYS        = 4,
	parameter int LINE_WORDS  = 32,
	parameter int TAG_WIDTH   = 7,
	parameter int STORE_WORDS = 65536
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         mode,
	input  logic [15:0]        address,
	input  logic signed [31:0] write_data,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] read_data,
	output logic               hit,
	output logic [31:0]        read_hit_count,
	output logic [31:0]        read_miss_count,
	output logic [31:0]        write_hit_count,
	output logic [31:0]        write_miss_count,
	output logic [31:0]        writeback_count
);

	localparam int OB  = $clog2(LINE_WORDS);
	localparam int SB  = $clog2(SETS);
	localparam int WYB = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int AW  = $clog2(STORE_WORDS);
	localparam int LAW = SB + WYB + OB;
	localparam int KW  = OB + 1;
	localparam int NL  = 2 ** (SB + WYB);
	localparam int TRW = WAYS * (TAG_WIDTH + WYB);

	typedef logic [WAYS-1:0][TAG_WIDTH-1:0] tags_t;
	typedef logic [WAYS-1:0][WYB-1:0]       ranks_t;

	typedef enum logic [3:0] {
		S_INIT, S_IDLE, S_LOOK, S_WB, S_FILL, S_ACC, S_DATA,
		S_FRD, S_FCHK, S_FNXT, S_RESP
	} state_t;

	state_t                 state_q;
	logic [AW-1:0]          clr_q;
	logic [1:0]             mode_q;
	logic [SB-1:0]          set_q;
	logic [OB-1:0]          off_q;
	logic [TAG_WIDTH-1:0]   tag_q;
	logic [31:0]            wdata_q;
	logic [WYB-1:0]         way_q;
	logic                   hit_q;
	tags_t                  ent_tag_q;
	ranks_t                 ent_rank_q;
	logic [TAG_WIDTH-1:0]   wb_tag_q;
	logic [SB-1:0]          fset_q;
	logic [WYB-1:0]         fway_q;
	logic [NL-1:0]          vld_q;
	logic [NL-1:0]          dty_q;
	logic [KW-1:0]          k_q;
	logic                   pv_s1;
	logic [OB-1:0]          pk_s1;
	logic [CNT_NUM-1:0][31:0] cnt_q;
	logic [31:0]            res_data_q;
	logic                   res_hit_q;

	// memory ports
	logic            tg_we, tg_re;
	logic [SB-1:0]   tg_waddr, tg_raddr;
	logic [TRW-1:0]  tg_wdata, tg_rdata;
	logic            ln_we, ln_re;
	logic [LAW-1:0]  ln_waddr, ln_raddr;
	logic [31:0]     ln_wdata, ln_rdata;
	logic            bk_we, bk_re;
	logic [AW-1:0]   bk_waddr, bk_raddr;
	logic [31:0]     bk_wdata, bk_rdata;

	tags_t           rd_tags;
	ranks_t          rd_ranks, init_ranks, new_ranks;
	logic [WYB-1:0]  hit_way, vic_way;
	logic            hit_found;
	logic [AW-1:0]   wb_base, fill_base;
	logic            out_free, in_acc, k_run, k_done;
	logic [SB+WYB-1:0] cur_line, fl_line;

	assign {rd_ranks, rd_tags} = tg_rdata;
	assign out_free = !out_valid || !out_stall;
	assign in_stall = (state_q != S_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign k_run    = (k_q != KW'(LINE_WORDS));
	assign k_done   = !k_run && !pv_s1;
	assign cur_line = {set_q, way_q};
	assign fl_line  = {fset_q, fway_q};
	assign wb_base   = AW'({wb_tag_q, set_q, {OB{1'b0}}});
	assign fill_base = AW'({tag_q, set_q, {OB{1'b0}}});

	// hit search, victim choice, rank reset pattern
	always_comb begin
		logic [WYB-1:0] best;
		logic           inv_found;
		hit_way   = '0;
		hit_found = 1'b0;
		vic_way   = '0;
		inv_found = 1'b0;
		best      = rd_ranks[0];
		for (int w = 0; w < WAYS; w++) begin
			init_ranks[w] = WYB'(w);
			if (!hit_found && vld_q[{set_q, WYB'(w)}] && rd_tags[w] == tag_q) begin
				hit_way   = WYB'(w);
				hit_found = 1'b1;
			end
			if (!inv_found && !vld_q[{set_q, WYB'(w)}]) begin
				vic_way   = WYB'(w);
				inv_found = 1'b1;
			end
		end
		if (!inv_found) begin
			for (int w = 1; w < WAYS; w++) begin
				if (rd_ranks[w] < best) begin
					best    = rd_ranks[w];
					vic_way = WYB'(w);
				end
			end
		end
	end

	// LRU touch of way_q
	always_comb begin
		for (int w = 0; w < WAYS; w++) begin
			if (ent_rank_q[w] > ent_rank_q[way_q]) begin
				new_ranks[w] = ent_rank_q[w] - 1'b1;
			end else begin
				new_ranks[w] = ent_rank_q[w];
			end
		end
		new_ranks[way_q] = WYB'(WAYS - 1);
	end

	// memory port control
	always_comb begin
		tg_we    = 1'b0;
		tg_waddr = set_q;
		tg_wdata = {new_ranks, ent_tag_q};
		tg_re    = 1'b0;
		tg_raddr = fset_q;
		ln_we    = 1'b0;
		ln_waddr = {cur_line, pk_s1};
		ln_wdata = bk_rdata;
		ln_re    = 1'b0;
		ln_raddr = {cur_line, k_q[OB-1:0]};
		bk_we    = 1'b0;
		bk_waddr = AW'(wb_base + AW'(pk_s1));
		bk_wdata = ln_rdata;
		bk_re    = 1'b0;
		bk_raddr = AW'(fill_base + AW'(k_q[OB-1:0]));
		case (state_q)
			S_INIT: begin
				bk_we    = 1'b1;
				bk_waddr = clr_q;
				bk_wdata = 32'(clr_q);
				tg_we    = (32'(clr_q) < 32'(SETS));
				tg_waddr = SB'(clr_q);
				tg_wdata = {init_ranks, tags_t'('0)};
			end
			S_IDLE: begin
				tg_re    = in_acc;
				tg_raddr = SB'(address >> OB);
			end
			S_WB: begin
				ln_re = k_run;
				bk_we = pv_s1;
			end
			S_FILL: begin
				bk_re = k_run;
				ln_we = pv_s1;
			end
			S_ACC: begin
				tg_we    = 1'b1;
				ln_raddr = {cur_line, off_q};
				ln_re    = (mode_q == MODE_READ);
				ln_we    = (mode_q == MODE_WRITE);
				ln_waddr = {cur_line, off_q};
				ln_wdata = wdata_q;
			end
			S_FRD: begin
				tg_re = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// control sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_INIT;
			clr_q     <= '0;
			vld_q     <= '0;
			dty_q     <= '0;
			cnt_q     <= '0;
			k_q       <= '0;
			pv_s1     <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			// a result taken while no new one is ready
			if (out_valid && !out_stall && state_q != S_RESP) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				S_INIT: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == AW'(STORE_WORDS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_acc) begin
						mode_q     <= mode;
						set_q      <= SB'(address >> OB);
						off_q      <= OB'(address);
						tag_q      <= TAG_WIDTH'(32'(address) >> (OB + SB));
						wdata_q    <= write_data;
						res_data_q <= '0;
						res_hit_q  <= 1'b0;
						fset_q     <= '0;
						fway_q     <= '0;
						if (mode == MODE_WRITE || mode == MODE_READ) begin
							state_q <= S_LOOK;
						end else if (mode == MODE_FLUSH) begin
							state_q <= S_FRD;
						end else begin
							state_q <= S_RESP;
						end
					end
				end
				S_LOOK: begin
					ent_tag_q  <= rd_tags;
					ent_rank_q <= rd_ranks;
					k_q        <= '0;
					pv_s1      <= 1'b0;
					hit_q      <= hit_found;
					wb_tag_q   <= rd_tags[vic_way];
					if (hit_found) begin
						way_q   <= hit_way;
						state_q <= S_ACC;
					end else begin
						way_q <= vic_way;
						if (vld_q[{set_q, vic_way}] && dty_q[{set_q, vic_way}]) begin
							state_q <= S_WB;
						end else begin
							state_q <= S_FILL;
						end
					end
				end
				// line copy: read at k, write in the next cycle
				S_WB, S_FILL: begin
					pv_s1 <= k_run;
					pk_s1 <= k_q[OB-1:0];
					if (k_run) begin
						k_q <= k_q + 1'b1;
					end
					if (k_done) begin
						k_q <= '0;
						if (state_q == S_WB) begin
							cnt_q[CNT_WB] <= cnt_q[CNT_WB] + 1'b1;
							state_q <= (mode_q == MODE_FLUSH) ? S_FNXT : S_FILL;
						end else begin
							vld_q[cur_line]  <= 1'b1;
							dty_q[cur_line]  <= 1'b0;
							ent_tag_q[way_q] <= tag_q;
							state_q          <= S_ACC;
						end
					end
				end
				S_ACC: begin
					res_hit_q <= hit_q;
					if (mode_q == MODE_WRITE) begin
						dty_q[cur_line] <= 1'b1;
						res_data_q      <= wdata_q;
						if (hit_q) begin
							cnt_q[CNT_WR_HIT] <= cnt_q[CNT_WR_HIT] + 1'b1;
						end else begin
							cnt_q[CNT_WR_MISS] <= cnt_q[CNT_WR_MISS] + 1'b1;
						end
						state_q <= S_RESP;
					end else begin
						state_q <= S_DATA;
					end
				end
				S_DATA: begin
					res_data_q <= ln_rdata;
					if (hit_q) begin
						cnt_q[CNT_RD_HIT] <= cnt_q[CNT_RD_HIT] + 1'b1;
					end else begin
						cnt_q[CNT_RD_MISS] <= cnt_q[CNT_RD_MISS] + 1'b1;
					end
					state_q <= S_RESP;
				end
				// flush walk over every line
				S_FRD: begin
					state_q <= S_FCHK;
				end
				S_FCHK: begin
					set_q    <= fset_q;
					way_q    <= fway_q;
					wb_tag_q <= rd_tags[fway_q];
					k_q      <= '0;
					pv_s1    <= 1'b0;
					if (vld_q[fl_line] && dty_q[fl_line]) begin
						state_q <= S_WB;
					end else begin
						state_q <= S_FNXT;
					end
				end
				S_FNXT: begin
					vld_q[fl_line] <= 1'b0;
					dty_q[fl_line] <= 1'b0;
					if (fway_q == WYB'(WAYS - 1)) begin
						fway_q <= '0;
						if (fset_q == SB'(SETS - 1)) begin
							state_q <= S_RESP;
						end else begin
							fset_q  <= fset_q + 1'b1;
							state_q <= S_FRD;
						end
					end else begin
						fway_q  <= fway_q + 1'b1;
						state_q <= S_FCHK;
					end
				end
				S_RESP: begin
					if (out_free) begin
						out_valid <= 1'b1;
						read_data <= res_data_q;
						hit       <= res_hit_q;
						if (mode_q == MODE_FLUSH) begin
							read_hit_count   <= cnt_q[CNT_RD_HIT];
							read_miss_count  <= cnt_q[CNT_RD_MISS];
							write_hit_count  <= cnt_q[CNT_WR_HIT];
							write_miss_count <= cnt_q[CNT_WR_MISS];
							writeback_count  <= cnt_q[CNT_WB];
							cnt_q            <= '0;
						end else begin
							read_hit_count   <= '0;
							read_miss_count  <= '0;
							write_hit_count  <= '0;
							write_miss_count <= '0;
							writeback_count  <= '0;
						end
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// tag and LRU rank store, one entry per set
	sac_ram #(.DEPTH(SETS), .WIDTH(TRW)) u_tags (
		.clk(clk), .we(tg_we), .waddr(tg_waddr), .wdata(tg_wdata),
		.re(tg_re), .raddr(tg_raddr), .rdata(tg_rdata)
	);

	// cached line words
	sac_ram #(.DEPTH(2 ** LAW), .WIDTH(32)) u_lines (
		.clk(clk), .we(ln_we), .waddr(ln_waddr), .wdata(ln_wdata),
		.re(ln_re), .raddr(ln_raddr), .rdata(ln_rdata)
	);

	// backing store
	sac_ram #(.DEPTH(STORE_WORDS), .WIDTH(32)) u_store (
		.clk(clk), .we(bk_we), .waddr(bk_waddr), .wdata(bk_wdata),
		.re(bk_re), .raddr(bk_raddr), .rdata(bk_rdata)
	);

endmodule

// ----- design/sac_ram.sv -----
// Simple dual-port synchronous RAM, one write port, one registered read port.
module sac_ram #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- design/sac_checker.sv -----
// Port-level checks for the cache, bound to the top level.
module sac_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [31:0] read_data,
	input logic        hit,
	input logic [31:0] read_hit_count,
	input logic [31:0] write_hit_count,
	input logic [31:0] writeback_count
);

	// a held result keeps its data
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(read_data) && $stable(hit))
		else $error("stalled result changed");

	// one request in flight: accept closes the input
	a_one: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("second request taken while busy");

	// counters only show on flush results, which never hit
	a_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && hit |-> read_hit_count == 0 && write_hit_count == 0
			&& writeback_count == 0)
		else $error("counters on an access result");

	// nothing delivered during reset
	a_rst: assert property (@(posedge clk) !arst_n |=> !out_valid)
		else $error("result during reset");

endmodule

bind set_assoc_writeback_lru_cache sac_checker u_sac_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall), .read_data(read_data), .hit(hit),
	.read_hit_count(read_hit_count), .write_hit_count(write_hit_count),
	.writeback_count(writeback_count)
);

// ----- test/set_assoc_writeback_lru_cache_tb.sv -----
// Testbench for the set-associative write-back LRU cache: directed and random requests against a behavioral cache.
`timescale 1ns / 1ps

module set_assoc_writeback_lru_cache_tb;
	import sac_pkg::*;

	localparam int SETS = 16;
	localparam int WAYS = 4;
	localparam int LW = 32;
	localparam int STORE = 65536;
	localparam int NL = SETS * WAYS;
	localparam longint LIMIT = 3000000;

	typedef struct packed {
		logic [1:0]  mode;
		logic [15:0] address;
		logic [31:0] write_data;
	} req_t;

	typedef struct packed {
		logic [31:0] read_data;
		logic        hit;
		logic [31:0] rd_hit;
		logic [31:0] rd_miss;
		logic [31:0] wr_hit;
		logic [31:0] wr_miss;
		logic [31:0] wb;
	} resp_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [1:0] mode = '0;
	logic [15:0] address = '0;
	logic signed [31:0] write_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [31:0] read_data;
	logic hit;
	logic [31:0] read_hit_count, read_miss_count, write_hit_count, write_miss_count;
	logic [31:0] writeback_count;

	set_assoc_writeback_lru_cache u_dut (.*);

	always #4 clk = ~clk;

	// behavioral cache state
	logic [6:0]  c_tag [NL];
	logic        c_valid [NL];
	logic        c_dirty [NL];
	logic [1:0]  c_rank [NL];
	logic [31:0] c_words [NL * LW];
	logic [31:0] mem [STORE];
	logic [31:0] c_cnt [CNT_NUM];

	req_t  pending_reqs [$];
	resp_t expected_resps [$];
	int    send_idle_pct = 34;
	int    recv_idle_pct = 63;
	int    mismatches = 0;
	int    n_acc = 0;
	int    n_pop = 0;
	bit    timed_out = 0;
	longint cycles = 0;

	function automatic void cache_reset();
		for (int i = 0; i < NL; i++) begin
			c_tag[i] = '0; c_valid[i] = 0; c_dirty[i] = 0; c_rank[i] = 2'(i % WAYS);
		end
		for (int i = 0; i < NL * LW; i++) c_words[i] = '0;
		for (int i = 0; i < STORE; i++) mem[i] = 32'(i);
		for (int i = 0; i < CNT_NUM; i++) c_cnt[i] = '0;
	endfunction

	function automatic void evict_line(int ln, int s);
		int base;
		base = ((int'(c_tag[ln]) * SETS + s) * LW) % STORE;
		for (int k = 0; k < LW; k++) mem[(base + k) % STORE] = c_words[ln * LW + k];
		c_cnt[CNT_WB]++;
	endfunction

	// compute the response of one request and update the cache model
	function automatic resp_t cache_access(req_t r);
		resp_t o;
		int off, s, tg, way, ln, base;
		logic [1:0] rk;
		bit h;
		o = '0;
		if (r.mode == MODE_FLUSH) begin
			for (int l = 0; l < NL; l++) begin
				if (c_valid[l] && c_dirty[l]) evict_line(l, l / WAYS);
				c_valid[l] = 0; c_dirty[l] = 0;
			end
			o.rd_hit = c_cnt[CNT_RD_HIT]; o.rd_miss = c_cnt[CNT_RD_MISS];
			o.wr_hit = c_cnt[CNT_WR_HIT]; o.wr_miss = c_cnt[CNT_WR_MISS];
			o.wb = c_cnt[CNT_WB];
			for (int j = 0; j < CNT_NUM; j++) c_cnt[j] = '0;
			return o;
		end
		if (r.mode != MODE_WRITE && r.mode != MODE_READ) return o;
		off = int'(r.address[4:0]); s = int'(r.address[8:5]); tg = int'(r.address[15:9]);
		way = WAYS; h = 0;
		for (int w = 0; w < WAYS; w++)
			if (!h && c_valid[s * WAYS + w] && c_tag[s * WAYS + w] == tg) begin
				way = w; h = 1;
			end
		if (!h) begin
			for (int w = WAYS - 1; w >= 0; w--) if (!c_valid[s * WAYS + w]) way = w;
			if (way == WAYS) begin
				rk = 2'd3; way = 0;
				for (int w = WAYS - 1; w >= 0; w--)
					if (c_rank[s * WAYS + w] <= rk) begin
						rk = c_rank[s * WAYS + w]; way = w;
					end
				if (c_dirty[s * WAYS + way]) evict_line(s * WAYS + way, s);
			end
			ln = s * WAYS + way;
			base = ((tg * SETS + s) * LW) % STORE;
			for (int k = 0; k < LW; k++) c_words[ln * LW + k] = mem[(base + k) % STORE];
			c_valid[ln] = 1; c_dirty[ln] = 0; c_tag[ln] = 7'(tg);
		end
		ln = s * WAYS + way;
		// LRU update
		rk = c_rank[ln];
		for (int w = 0; w < WAYS; w++)
			if (c_rank[s * WAYS + w] > rk) c_rank[s * WAYS + w]--;
		c_rank[ln] = 2'(WAYS - 1);
		if (r.mode == MODE_READ) begin
			o.read_data = c_words[ln * LW + off];
			if (h) c_cnt[CNT_RD_HIT]++; else c_cnt[CNT_RD_MISS]++;
		end else begin
			c_words[ln * LW + off] = r.write_data;
			c_dirty[ln] = 1;
			o.read_data = r.write_data;
			if (h) c_cnt[CNT_WR_HIT]++; else c_cnt[CNT_WR_MISS]++;
		end
		o.hit = h;
		return o;
	endfunction

	// driver: present the head of the queue, drop it once the monitor saw it accepted
	always @(negedge clk) begin
		logic nxt_valid;
		if (arst_n) begin
			nxt_valid = in_valid;
			if (n_pop != n_acc) begin
				void'(pending_reqs.pop_front());
				n_pop++;
				nxt_valid = 1'b0;
			end
			if (!nxt_valid && pending_reqs.size() > 0
					&& $urandom_range(99) >= send_idle_pct) begin
				nxt_valid = 1'b1;
				mode <= pending_reqs[0].mode;
				address <= pending_reqs[0].address;
				write_data <= pending_reqs[0].write_data;
			end
			in_valid <= nxt_valid;
			out_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	// monitor: predict on accepted requests, check accepted responses
	always @(posedge clk) begin
		req_t r;
		resp_t got, exp;
		if (arst_n) begin
			cycles <= cycles + 1;
			if (in_valid && !in_stall) begin
				n_acc++;
				r = '{mode, address, write_data};
				expected_resps.push_back(cache_access(r));
			end
			if (out_valid && !out_stall) begin
				got = '{read_data, hit, read_hit_count, read_miss_count, write_hit_count,
					write_miss_count, writeback_count};
				if (expected_resps.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) $display("unexpected response %h", got);
				end else begin
					exp = expected_resps.pop_front();
					if (got !== exp) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: expected %h got %h", exp, got);
					end
				end
			end
		end
	end

	// random request, mostly from a small address pool to get hits and evictions
	function automatic req_t rand_req();
		req_t r;
		int p;
		p = $urandom_range(99);
		r.mode = (p < 45) ? MODE_WRITE : (p < 97) ? MODE_READ : (p < 99) ? MODE_FLUSH : MODE_UNUSED;
		if ($urandom_range(3) == 0) r.address = 16'($urandom);
		else r.address = {4'($urandom_range(7)) + 3'd0, 3'($urandom), 4'($urandom_range(1)),
			5'($urandom)};
		r.write_data = $urandom;
		return r;
	endfunction

	task automatic wait_drain();
		while (pending_reqs.size() > 0 || in_valid || expected_resps.size() > 0)
			@(posedge clk);
	endtask

	initial begin
		cache_reset();
		repeat (11) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		// directed: extremes, all modes, eviction with dirty victims, unused mode
		pending_reqs.push_back('{MODE_READ, 16'h0000, 32'h0});
		pending_reqs.push_back('{MODE_WRITE, 16'hffff, 32'h7fffffff});
		pending_reqs.push_back('{MODE_READ, 16'hffff, 32'hffffffff});
		pending_reqs.push_back('{MODE_WRITE, 16'h0000, 32'h80000000});
		for (int t = 0; t < 6; t++)
			pending_reqs.push_back('{MODE_WRITE, 16'(t << 9) | 16'h0021, 32'(t * 3 + 1)});
		for (int t = 0; t < 6; t++)
			pending_reqs.push_back('{MODE_READ, 16'(t << 9) | 16'h0021, 32'h0});
		pending_reqs.push_back('{MODE_UNUSED, 16'h1234, 32'hdeadbeef});
		pending_reqs.push_back('{MODE_FLUSH, 16'h0, 32'h0});
		pending_reqs.push_back('{MODE_READ, 16'h0021, 32'h0});
		pending_reqs.push_back('{MODE_FLUSH, 16'hffff, 32'hffffffff});

		for (int phase = 0; phase < 3; phase++) begin
			for (int i = 0; i < 150; i++) pending_reqs.push_back(rand_req());
			wait_drain();
			send_idle_pct = (phase == 0) ? 63 : 0;
			recv_idle_pct = (phase == 0) ? 34 : 0;
		end
		pending_reqs.push_back('{MODE_FLUSH, 16'h0, 32'h0});
		wait_drain();
		repeat (200) @(posedge clk);
		if (mismatches == 0 && expected_resps.size() == 0)
			$display("PASS set_assoc_writeback_lru_cache");
		else
			$display("FAIL set_assoc_writeback_lru_cache");
		$finish;
	end

	// timeout guard; covers the clearing pass after reset
	always @(posedge clk) begin
		if (cycles > LIMIT + STORE && !timed_out) begin
			timed_out = 1;
			$display("FAIL set_assoc_writeback_lru_cache");
			$finish;
		end
	end

endmodule

// ----- files.f -----
design/sac_pkg.sv
design/sac_ram.sv
design/set_assoc_writeback_lru_cache.sv
design/sac_checker.sv
test/set_assoc_writeback_lru_cache_tb.sv
